// ===== rtl/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by lpfd_parse and length_prefixed_frame_deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

  // header is 8 bytes; count runs 0..7, byte 7 closes the header
  localparam int unsigned HDR_BYTES = 8;
  localparam logic [2:0]  HDR_LAST  = 3'(HDR_BYTES - 1);

  // body padded to a multiple of 4, computed at 33 bits
  localparam logic [32:0] PAD_ADD  = 33'd3;
  localparam logic [32:0] PAD_MASK = ~33'd3;

  localparam logic [31:0] MAX_BODY_RESET = 32'h0010_0000;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] command;
    logic [31:0] length;
    logic [7:0]  data;
    logic [31:0] index;
    logic        last;
  } result_t;

endpackage

// ===== rtl/lpfd_parse.sv =====
// Header collection, body counting and result decode for the deframer.
// Depends on lpfd_pkg. State advances only on fire_i.
`timescale 1ns / 1ps

module lpfd_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  input  logic [31:0]           max_len_i,
  output lpfd_pkg::result_t     res_o,
  output logic                  err_o
);

  logic [55:0] shift_q, shift_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        in_body_q, in_body_d;
  logic [31:0] cmd_q, cmd_d;
  logic [31:0] len_q, len_d;
  logic [32:0] padded_q, padded_d;
  logic [32:0] body_q, body_d;
  logic        err_q, err_d;

  logic [31:0] len_w;
  logic [32:0] padded_w;
  logic [32:0] body_inc;

  assign len_w    = {byte_i, shift_q[55:32]};
  assign padded_w = ({1'b0, len_w} + lpfd_pkg::PAD_ADD) & lpfd_pkg::PAD_MASK;
  assign body_inc = body_q + 33'd1;

  always_comb begin
    shift_d   = shift_q;
    cnt_d     = cnt_q;
    in_body_d = in_body_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    padded_d  = padded_q;
    body_d    = body_q;
    err_d     = err_q;
    res_o     = '0;
    res_o.kind    = lpfd_pkg::KIND_PAYLOAD;
    res_o.command = cmd_q;
    res_o.length  = len_q;

    if (!err_q) begin
      if (!in_body_q) begin
        if (cnt_q != lpfd_pkg::HDR_LAST) begin
          for (int k = 0; k < 7; k++) begin
            if (cnt_q == 3'(k)) begin
              shift_d[8*k +: 8] = byte_i;
            end
          end
          cnt_d = cnt_q + 3'd1;
        end else begin
          cmd_d    = shift_q[31:0];
          len_d    = len_w;
          padded_d = padded_w;
          shift_d  = '0;
          cnt_d    = '0;
          body_d   = '0;
          res_o.command = shift_q[31:0];
          res_o.length  = len_w;
          if (padded_w > {1'b0, max_len_i}) begin
            err_d       = 1'b1;
            res_o.valid = 1'b1;
            res_o.kind  = lpfd_pkg::KIND_OVERSIZE;
          end else if (padded_w == '0) begin
            res_o.valid = 1'b1;
            res_o.kind  = lpfd_pkg::KIND_EMPTY;
          end else begin
            in_body_d = 1'b1;
          end
        end
      end else begin
        // payload bytes first, then silent padding
        if (body_q < {1'b0, len_q}) begin
          res_o.valid = 1'b1;
          res_o.kind  = lpfd_pkg::KIND_PAYLOAD;
          res_o.data  = byte_i;
          res_o.index = body_q[31:0];
          res_o.last  = (body_inc == {1'b0, len_q});
        end
        body_d = body_inc;
        if (body_inc >= padded_q) begin
          in_body_d = 1'b0;
          body_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      cnt_q     <= '0;
      in_body_q <= 1'b0;
      cmd_q     <= '0;
      len_q     <= '0;
      padded_q  <= '0;
      body_q    <= '0;
      err_q     <= 1'b0;
    end else if (fire_i) begin
      shift_q   <= shift_d;
      cnt_q     <= cnt_d;
      in_body_q <= in_body_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      padded_q  <= padded_d;
      body_q    <= body_d;
      err_q     <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer: input register,
// output register and config register. Depends on lpfd_pkg, lpfd_parse.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   data_byte_i
// out      source     out_valid_o / out_stall_i kind_o, command_o, payload_length_o,
//                                               payload_byte_o, byte_index_o, last_byte_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (max_body_length)
//
// One byte per clock sustained while no result is stalled at the output; a byte's result
// passes through the input register, then the output register, before it can transfer out.
// Parsing happens as a byte leaves the input register into a free output slot.
// in_stall_o rises only while the input register is full and the output holds a
// result that is stalled. After an oversize error every byte is dropped until reset.
// Reset clears parse state and sets max_body_length to 1 MiB; cfg_ready_o is always high.

module length_prefixed_frame_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [31:0]         command_o,
  output logic [31:0]         payload_length_o,
  output logic [7:0]          payload_byte_o,
  output logic [31:0]         byte_index_o,
  output logic                last_byte_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic [31:0]       max_len_q;
  logic              out_free;
  logic              fire;
  lpfd_pkg::result_t res;
  logic              err;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_o || !out_stall_i;
  assign fire        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;

  lpfd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res),
    .err_o     (err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpfd_pkg::MAX_BODY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      kind_o           <= res.kind;
      command_o        <= res.command;
      payload_length_o <= res.length;
      payload_byte_o   <= res.data;
      byte_index_o     <= res.index;
      last_byte_o      <= res.last;
    end
  end

  // the oversize error only clears on reset
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err |=> err)
    else $error("error latch dropped");

  a_kind_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == lpfd_pkg::KIND_PAYLOAD || kind_o == lpfd_pkg::KIND_EMPTY ||
                     kind_o == lpfd_pkg::KIND_OVERSIZE))
    else $error("illegal result kind");

  a_nonpayload_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != lpfd_pkg::KIND_PAYLOAD) |->
      (payload_byte_o == '0 && byte_index_o == '0 && !last_byte_o))
    else $error("non-payload result carries byte fields");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_no_result_after_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(err) |-> !(fire && res.valid))
    else $error("result produced after oversize error");

endmodule

// ===== verif/length_prefixed_frame_deframer_tb.sv =====
// Self-checking testbench for length_prefixed_frame_deframer: framed byte streams
// under random gaps and stalls, checked against a frame predictor class.
// Depends on lpfd_pkg and the length_prefixed_frame_deframer RTL.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_tb;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    lpfd_pkg::kind_e kind;
    logic [31:0]     command;
    logic [31:0]     length;
    logic [7:0]      data;
    logic [31:0]     index;
    logic            last;
  } frame_result_t;

  // Tracks the deframer state and queues the result each accepted byte must produce.
  class frame_predictor;
    logic [31:0]   max_body;
    logic [55:0]   hdr_shift;
    int unsigned   hdr_count;
    bit            in_body;
    logic [31:0]   cur_command;
    logic [31:0]   cur_length;
    logic [32:0]   padded_len;
    logic [32:0]   body_count;
    bit            oversize_seen;
    frame_result_t due_results[$];
    int unsigned   errors;

    function new();
      max_body      = lpfd_pkg::MAX_BODY_RESET;
      hdr_shift     = '0;
      hdr_count     = 0;
      in_body       = 1'b0;
      cur_command   = '0;
      cur_length    = '0;
      padded_len    = '0;
      body_count    = '0;
      oversize_seen = 1'b0;
      errors        = 0;
    endfunction

    function void set_max_body(logic [31:0] value);
      max_body = value;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void queue_result(lpfd_pkg::kind_e kind, logic [7:0] data, logic [31:0] index,
                               logic last);
      frame_result_t r;
      r.kind    = kind;
      r.command = cur_command;
      r.length  = cur_length;
      r.data    = data;
      r.index   = index;
      r.last    = last;
      due_results.push_back(r);
    endfunction

    function void take_stream_byte(logic [7:0] b);
      if (oversize_seen) return;
      if (!in_body) begin
        if (hdr_count < lpfd_pkg::HDR_BYTES - 1) begin
          hdr_shift |= 56'(b) << (8 * hdr_count);
          hdr_count++;
          return;
        end
        cur_command = hdr_shift[31:0];
        cur_length  = {b, hdr_shift[55:32]};
        // 33-bit round-up so 0xFFFFFFFD.. do not wrap to zero
        padded_len  = {1'b0, cur_length} + 33'd3;
        padded_len[1:0] = 2'b00;
        hdr_shift   = '0;
        hdr_count   = 0;
        body_count  = '0;
        if (padded_len > {1'b0, max_body}) begin
          oversize_seen = 1'b1;
          queue_result(lpfd_pkg::KIND_OVERSIZE, 8'h00, 32'h0, 1'b0);
          return;
        end
        if (padded_len == 33'd0) begin
          queue_result(lpfd_pkg::KIND_EMPTY, 8'h00, 32'h0, 1'b0);
          return;
        end
        in_body = 1'b1;
        return;
      end
      if (body_count < {1'b0, cur_length})
        queue_result(lpfd_pkg::KIND_PAYLOAD, b, body_count[31:0],
                     (body_count + 33'd1) == {1'b0, cur_length});
      body_count++;
      if (body_count >= padded_len) begin
        in_body    = 1'b0;
        body_count = '0;
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_frame_result(logic [1:0] kind, logic [31:0] command, logic [31:0] length,
                                     logic [7:0] data, logic [31:0] index, logic last);
      frame_result_t r;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d cmd 0x%0h len %0d",
                 $time, kind, command, length);
        return;
      end
      r = due_results.pop_front();
      compare_field("kind", r.kind, kind);
      compare_field("command", r.command, command);
      compare_field("payload_length", r.length, length);
      compare_field("payload_byte", r.data, data);
      compare_field("byte_index", r.index, index);
      compare_field("last_byte", r.last, last);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] command_o;
  logic [31:0] payload_length_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] byte_index_o;
  logic        last_byte_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = 32'h0;

  frame_predictor sb;
  bit             calm = 1'b0;
  logic [31:0]    max_now = lpfd_pkg::MAX_BODY_RESET;
  int unsigned    stuck_cycles = 0;

  length_prefixed_frame_deframer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .last_byte_o      (last_byte_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // result side: check on each transfer, then pick the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        sb.check_frame_result(kind_o, command_o, payload_length_o, payload_byte_o,
                              byte_index_o, last_byte_o);
      out_stall_i <= idle_now();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge where the byte transferred
  task automatic send_byte(logic [7:0] b);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_stream_byte(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_body(logic [31:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_max_body(value);
    max_now = value;
    cfg_valid_i <= 1'b0;
  endtask

  // fill < 0 gives random payload bytes; padding is always random
  task automatic send_frame(logic [31:0] command, logic [31:0] length, int fill);
    int unsigned padded;
    padded = (length + 3) & ~32'd3;
    for (int k = 0; k < 4; k++) send_byte(command[8*k +: 8]);
    for (int k = 0; k < 4; k++) send_byte(length[8*k +: 8]);
    for (int unsigned i = 0; i < padded; i++) begin
      if (i < length && fill >= 0)
        send_byte(8'(fill));
      else
        send_byte(8'($urandom));
    end
  endtask

  function automatic int unsigned pick_length(logic [31:0] ceiling, int unsigned cap);
    longint unsigned top;
    top = {ceiling[31:2], 2'b00};
    if (top > cap) top = cap;
    case ($urandom_range(7))
      0:          return 0;
      1:          return int'(top);
      2, 3, 4, 5: return $urandom_range((top < 12) ? int'(top) : 12);
      default:    return $urandom_range(int'(top));
    endcase
  endfunction

  task automatic random_frames(int unsigned cap, int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = pick_length(max_now, cap);
      send_frame($urandom, len, -1);
      sent += 8 + ((len + 3) & ~32'd3);
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message with all-ones command, one-byte payload with padding
    send_frame(32'hFFFF_FFFF, 32'd0, -1);
    send_frame(32'h0000_0000, 32'd1, 8'hFF);

    random_frames(255, 700);

    // only empty messages fit when the limit is zero
    write_max_body(32'd0);
    for (int i = 0; i < 12; i++) send_frame($urandom, 32'd0, -1);

    // padded length equal to the limit is allowed
    write_max_body(32'd12);
    send_frame($urandom, 32'd9, 8'h00);
    random_frames(255, 300);

    write_max_body(32'd64);
    calm = 1'b1;
    random_frames(255, 400);
    calm = 1'b0;

    write_max_body(32'hFFFF_FFFF);
    random_frames(200, 120);
    drain();
    random_frames(200, 130);

    // max length rounds up past 32 bits: oversize, then everything is dropped
    send_frame($urandom, 32'hFFFF_FFFF, -1);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom));
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
